// File: rtl/sfcd_pkg.sv
// shared types, constants and the crc byte update for the frame deframer
package sfcd_pkg;

   // payload buffer sizing
   localparam int MaxPayload    = 32;
   localparam int PayAddrWidth  = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
   localparam int PayCountWidth = $clog2(MaxPayload + 1);

   // crc-16/modbus, reflected
   localparam logic [15:0] CrcInit = 16'hFFFF;
   localparam logic [15:0] CrcPoly = 16'hA001;

   // register reset values
   localparam logic [7:0]  ResetStartOne = 8'd0;
   localparam logic [7:0]  ResetStartTwo = 8'd0;
   localparam logic [7:0]  ResetVersion  = 8'd1;
   localparam logic [15:0] ResetTimeout  = 16'd50;

   // configuration port
   localparam int PaddrWidth = 4;
   localparam logic [1:0] RegStartOne = 2'd0;
   localparam logic [1:0] RegStartTwo = 2'd1;
   localparam logic [1:0] RegVersion  = 2'd2;
   localparam logic [1:0] RegTimeout  = 2'd3;

   // request opcodes and result kinds
   localparam logic OpByte      = 1'b0;
   localparam logic OpTick      = 1'b1;
   localparam logic KindReport  = 1'b0;
   localparam logic KindPayload = 1'b1;

   typedef enum logic [2:0] {
      StatusOk      = 3'd0,
      StatusCrc     = 3'd1,
      StatusLength  = 3'd2,
      StatusVersion = 3'd3,
      StatusTimeout = 3'd4
   } status_type;

   typedef struct packed {
      logic       opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      status_type  status;
      logic [7:0]  frame_type;
      logic [7:0]  sequence_res;
      logic [7:0]  payload_length;
      logic [15:0] detail;
      logic [7:0]  payload_byte;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  start_one;
      logic [7:0]  start_two;
      logic [7:0]  version;
      logic [15:0] timeout;
   } cfg_type;

   // report raised by the parser for one request
   typedef struct packed {
      logic        valid;
      status_type  status;
      logic [7:0]  frame_type;
      logic [7:0]  sequence_res;
      logic [7:0]  payload_length;
      logic [15:0] detail;
      logic        readout;
   } report_type;

   typedef struct packed {
      logic                    en;
      logic [PayAddrWidth-1:0] addr;
      logic [7:0]              data;
   } pay_write_type;

   // one byte through the reflected crc, eight narrow steps
   function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/sof_framed_crc16_deframer.sv
// top level: configuration registers, parser, payload buffer and result sequencer
//
// Request channel (req_valid/req_ready/req_data) carries either a received byte
// or one time tick. The parser handles one request per cycle of acceptance and
// writes payload bytes into a 32-entry synchronous buffer as they arrive.
// Result channel (rsp_valid/rsp_ready/rsp_data) carries frame and error reports
// and, after a good report, the frame's payload bytes read back from the buffer.
// A request that raises a report shows it on the result channel in the cycle after
// acceptance. Requests are taken while no result is pending, so a request that
// raises a report holds off the next request until the receiver takes the
// report, however long it holds rsp_ready low.
// Payload readout goes through the buffer's single registered read port: each
// payload byte is read from the buffer, then moved to the output register, and
// any stall holds it; new requests wait until the frame's last byte is taken.
// When the receiver stalls, the current result holds and no request is taken.
// Reset (synchronous, active high) restores the registers to their defaults and
// puts the parser into the hunt for the first start byte; the payload buffer
// needs no clearing since only entries written in the current frame are read.
// The APB-style port writes registers at byte addresses 0, 4, 8 and 12.
module sof_framed_crc16_deframer (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  sfcd_pkg::req_type                req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output sfcd_pkg::rsp_type                rsp_data,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [sfcd_pkg::PaddrWidth-1:0]  paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   import sfcd_pkg::*;

   typedef enum logic [2:0] {
      SeqIdle  = 3'b001,
      SeqHold  = 3'b010,
      SeqFetch = 3'b100
   } seq_type;

   cfg_type                  cfg_ff;
   seq_type                  seq_ff, seq_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [PayCountWidth-1:0] cnt_ff, cnt_in;
   logic                     accept;
   logic                     rsp_take;
   logic                     csr_write;
   logic [1:0]               reg_index;
   report_type               report;
   pay_write_type            pay_wr;
   logic                     rd_en;
   logic [7:0]               rd_data;

   assign pready    = 1'b1;
   assign reg_index = paddr[3:2];
   assign csr_write = psel && penable && pwrite;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_one <= ResetStartOne;
         cfg_ff.start_two <= ResetStartTwo;
         cfg_ff.version   <= ResetVersion;
         cfg_ff.timeout   <= ResetTimeout;
      end else if (csr_write) begin
         case (reg_index)
            RegStartOne: cfg_ff.start_one <= pwdata[7:0];
            RegStartTwo: cfg_ff.start_two <= pwdata[7:0];
            RegVersion:  cfg_ff.version   <= pwdata[7:0];
            RegTimeout:  cfg_ff.timeout   <= pwdata[15:0];
            default:     cfg_ff.start_one <= cfg_ff.start_one;
         endcase
      end
   end

   // register read-back
   always_comb begin
      case (reg_index)
         RegStartOne: prdata = {24'h0, cfg_ff.start_one};
         RegStartTwo: prdata = {24'h0, cfg_ff.start_two};
         RegVersion:  prdata = {24'h0, cfg_ff.version};
         RegTimeout:  prdata = {16'h0, cfg_ff.timeout};
         default:     prdata = 32'h0;
      endcase
   end

   // request handshake
   assign req_ready = (seq_ff == SeqIdle) && !rsp_valid_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_take  = rsp_valid_ff && rsp_ready;

   sfcd_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .item   (req_data),
      .cfg    (cfg_ff),
      .report (report),
      .pay_wr (pay_wr)
   );

   sfcd_payload_ram u_ram (
      .clock   (clock),
      .wr      (pay_wr),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[PayAddrWidth-1:0]),
      .rd_data (rd_data)
   );

   // result sequencer: report, then payload readout
   always_comb begin
      seq_in       = seq_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      cnt_in       = cnt_ff;
      rd_en        = 1'b0;
      case (seq_ff)
         SeqIdle: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
            end
            if (report.valid) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.item_kind      = KindReport;
               rsp_data_in.status         = report.status;
               rsp_data_in.frame_type     = report.frame_type;
               rsp_data_in.sequence_res   = report.sequence_res;
               rsp_data_in.payload_length = report.payload_length;
               rsp_data_in.detail         = report.detail;
               rsp_data_in.payload_byte   = 8'd0;
               rsp_data_in.last           = !report.readout;
               if (report.readout) begin
                  seq_in = SeqHold;
                  cnt_in = '0;
               end
            end
         end
         SeqHold: begin
            if (rsp_take) begin
               rsp_valid_in = 1'b0;
               if (rsp_data_ff.last) begin
                  seq_in = SeqIdle;
               end else begin
                  rd_en  = 1'b1;
                  seq_in = SeqFetch;
               end
            end
         end
         SeqFetch: begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.item_kind    = KindPayload;
            rsp_data_in.status       = StatusOk;
            rsp_data_in.detail       = 16'd0;
            rsp_data_in.payload_byte = rd_data;
            rsp_data_in.last         = (8'(cnt_ff) + 8'd1 == rsp_data_ff.payload_length);
            cnt_in                   = cnt_ff + PayCountWidth'(1);
            seq_in                   = SeqHold;
         end
         default: begin
            seq_in       = SeqIdle;
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   // sequencer control
   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff       <= SeqIdle;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         seq_ff       <= seq_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // no request is taken while a result waits
   a_no_req_with_rsp: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request ready while a result is pending");

   // a payload fetch always lands in the output register in the next cycle
   a_fetch_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      (seq_ff == SeqFetch) |=> rsp_valid)
      else $error("payload fetch did not produce a result");

   // after a non-final result the block keeps requests out for the readout
   a_readout_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=> (!rsp_valid && !req_ready))
      else $error("readout did not hold off requests");

   // a request is only taken with the sequencer idle
   a_accept_when_idle: assert property (@(posedge clock) disable iff (reset)
      accept |-> (seq_ff == SeqIdle) && !rsp_valid_ff)
      else $error("request accepted during readout");

endmodule

// File: rtl/sfcd_payload_ram.sv
// payload buffer: one write port, one registered read port
module sfcd_payload_ram (
   input  logic                             clock,
   input  sfcd_pkg::pay_write_type          wr,
   input  logic                             rd_en,
   input  logic [sfcd_pkg::PayAddrWidth-1:0] rd_addr,
   output logic [7:0]                       rd_data
);
   import sfcd_pkg::*;

   logic [7:0] mem [MaxPayload];

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// File: rtl/sfcd_parser.sv
// frame parser: start hunt, header with length check, payload write, crc and version check and timeout
module sfcd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  sfcd_pkg::req_type        item,
   input  sfcd_pkg::cfg_type        cfg,
   output sfcd_pkg::report_type     report,
   output sfcd_pkg::pay_write_type  pay_wr
);
   import sfcd_pkg::*;

   typedef enum logic [5:0] {
      PhHunt     = 6'b000001,
      PhStartTwo = 6'b000010,
      PhHeader   = 6'b000100,
      PhPayload  = 6'b001000,
      PhCrcLow   = 6'b010000,
      PhCrcHigh  = 6'b100000
   } phase_type;

   phase_type              phase_ff, phase_in, clr_phase;
   logic [7:0]             version_ff, version_in;
   logic [7:0]             type_ff, type_in;
   logic [7:0]             seq_ff, seq_in;
   logic [7:0]             len_ff, len_in;
   logic [1:0]             hcount_ff, hcount_in;
   logic [PayCountWidth-1:0] pcount_ff, pcount_in;
   logic [15:0]            crc_ff, crc_in;
   logic [7:0]             crc_low_ff, crc_low_in;
   logic [15:0]            idle_ff, idle_in;
   logic                   clear;
   logic [7:0]             b;
   logic [15:0]            idle_sat;
   logic [15:0]            rx_crc;

   assign b      = item.data_byte;
   assign rx_crc = {b, crc_low_ff};
   assign idle_sat = (idle_ff == 16'hFFFF) ? idle_ff : idle_ff + 16'd1;

   // next state for one request
   always_comb begin
      phase_in   = phase_ff;
      version_in = version_ff;
      type_in    = type_ff;
      seq_in     = seq_ff;
      len_in     = len_ff;
      hcount_in  = hcount_ff;
      pcount_in  = pcount_ff;
      crc_in     = crc_ff;
      crc_low_in = crc_low_ff;
      idle_in    = idle_ff;
      clear      = 1'b0;
      clr_phase  = PhHunt;
      report     = '0;
      report.status         = StatusOk;
      report.frame_type     = type_ff;
      report.sequence_res   = seq_ff;
      report.payload_length = len_ff;
      pay_wr      = '0;
      pay_wr.addr = pcount_ff[PayAddrWidth-1:0];
      pay_wr.data = b;

      if (accept) begin
         if (item.opcode == OpTick) begin
            // idle ticks only count mid-frame
            if (phase_ff != PhHunt) begin
               idle_in = idle_sat;
               if (idle_sat >= cfg.timeout) begin
                  report.valid  = 1'b1;
                  report.status = StatusTimeout;
                  clear         = 1'b1;
               end
            end
         end else begin
            idle_in = 16'd0;
            case (phase_ff)
               PhHunt: begin
                  if (b == cfg.start_one) begin
                     clear     = 1'b1;
                     clr_phase = PhStartTwo;
                  end
               end
               PhStartTwo: begin
                  // start two wins over a repeated start one
                  if (b == cfg.start_two) begin
                     clear     = 1'b1;
                     clr_phase = PhHeader;
                  end else if (b != cfg.start_one) begin
                     clear = 1'b1;
                  end
               end
               PhHeader: begin
                  crc_in    = crc16_feed(crc_ff, b);
                  hcount_in = hcount_ff + 2'd1;
                  case (hcount_ff)
                     2'd0:    version_in = b;
                     2'd1:    type_in    = b;
                     2'd2:    seq_in     = b;
                     default: len_in     = b;
                  endcase
                  if (hcount_ff == 2'd3) begin
                     pcount_in = '0;
                     if (b > 8'(MaxPayload)) begin
                        report.valid          = 1'b1;
                        report.status         = StatusLength;
                        report.payload_length = b;
                        report.detail         = {8'h00, b};
                        clear                 = 1'b1;
                     end else begin
                        phase_in = (b == 8'd0) ? PhCrcLow : PhPayload;
                     end
                  end
               end
               PhPayload: begin
                  pay_wr.en = 1'b1;
                  crc_in    = crc16_feed(crc_ff, b);
                  pcount_in = pcount_ff + PayCountWidth'(1);
                  if (8'(pcount_ff) + 8'd1 >= len_ff) begin
                     phase_in = PhCrcLow;
                  end
               end
               PhCrcLow: begin
                  crc_low_in = b;
                  phase_in   = PhCrcHigh;
               end
               PhCrcHigh: begin
                  report.valid = 1'b1;
                  clear        = 1'b1;
                  if (rx_crc != crc_ff) begin
                     report.status = StatusCrc;
                     report.detail = rx_crc;
                  end else if (version_ff != cfg.version) begin
                     report.status = StatusVersion;
                     report.detail = {8'h00, version_ff};
                  end else begin
                     report.status  = StatusOk;
                     report.detail  = rx_crc;
                     report.readout = (len_ff != 8'd0);
                  end
               end
               default: begin
                  clear = 1'b1;
               end
            endcase
         end

         // back to the hunt, optionally straight into a start phase
         if (clear) begin
            phase_in   = clr_phase;
            version_in = 8'd0;
            type_in    = 8'd0;
            seq_in     = 8'd0;
            len_in     = 8'd0;
            hcount_in  = 2'd0;
            pcount_in  = '0;
            crc_in     = CrcInit;
            crc_low_in = 8'd0;
            idle_in    = 16'd0;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PhHunt;
         version_ff <= 8'd0;
         type_ff    <= 8'd0;
         seq_ff     <= 8'd0;
         len_ff     <= 8'd0;
         hcount_ff  <= 2'd0;
         pcount_ff  <= '0;
         crc_ff     <= CrcInit;
         crc_low_ff <= 8'd0;
         idle_ff    <= 16'd0;
      end else begin
         phase_ff   <= phase_in;
         version_ff <= version_in;
         type_ff    <= type_in;
         seq_ff     <= seq_in;
         len_ff     <= len_in;
         hcount_ff  <= hcount_in;
         pcount_ff  <= pcount_in;
         crc_ff     <= crc_in;
         crc_low_ff <= crc_low_in;
         idle_ff    <= idle_in;
      end
   end

endmodule

// File: test/sof_framed_crc16_deframer_tb.sv
// self-checking testbench for the framed crc-16 deframer: directed and random frames
module sof_framed_crc16_deframer_tb;
   import sfcd_pkg::*;

   // parser phases of the local deframer copy
   typedef enum logic [2:0] {
      PhHunt, PhStartTwo, PhHeader, PhPayload, PhCrcLow, PhCrcHigh
   } frame_phase_type;

   // payload fill patterns for directed frames
   typedef enum logic [1:0] {
      FillRandom, FillOnes, FillZeros, FillAlternate
   } fill_mode_type;

   localparam int WholeFrame = -1;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  psel      = 1'b0;
   logic                  penable   = 1'b0;
   logic                  pwrite    = 1'b0;
   logic [PaddrWidth-1:0] paddr     = '0;
   logic [31:0]           pwdata    = '0;
   logic [31:0]           prdata;
   logic                  pready;

   // idling controls for both sides
   bit req_gaps   = 1'b1;
   bit rsp_stalls = 1'b1;

   // register shadows
   logic [7:0]  cfg_start_one = ResetStartOne;
   logic [7:0]  cfg_start_two = ResetStartTwo;
   logic [7:0]  cfg_version   = ResetVersion;
   logic [15:0] cfg_timeout   = ResetTimeout;

   // deframer state copy
   frame_phase_type parser_phase  = PhHunt;
   logic [31:0]     header_word   = '0;
   int              header_taken  = 0;
   int              payload_taken = 0;
   logic [7:0]      payload_copy [MaxPayload];
   logic [15:0]     crc_acc       = CrcInit;
   logic [7:0]      crc_low       = '0;
   logic [15:0]     idle_count    = '0;

   // payload prepared for the next directed or random frame
   logic [7:0]   frame_payload [MaxPayload];

   rsp_type awaited_results [$];
   rsp_type oldest_result;

   int fail_count         = 0;
   int sent_requests      = 0;
   int results_seen       = 0;
   int payload_bytes_seen = 0;
   int report_tally [5]   = '{default: 0};

   sof_framed_crc16_deframer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tb: failure");
      $finish;
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= !rsp_stalls || ($urandom_range(0, 99) >= 13);
   end

   // reflected crc-16/modbus, one bit at a time
   function automatic logic [15:0] crc16_modbus_step(input logic [15:0] acc,
                                                     input logic [7:0] value);
      logic [15:0] c;
      c = acc;
      for (int k = 0; k < 8; k++) begin
         if (c[0] ^ value[k]) c = (c >> 1) ^ CrcPoly;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic void restart_hunt();
      parser_phase  = PhHunt;
      header_word   = '0;
      header_taken  = 0;
      payload_taken = 0;
      crc_low       = '0;
      crc_acc       = CrcInit;
      idle_count    = '0;
   endfunction

   function automatic void queue_result(input logic kind, input status_type st,
                                        input logic [15:0] detail, input logic [7:0] pbyte,
                                        input logic last);
      rsp_type r;
      r.item_kind      = kind;
      r.status         = st;
      r.frame_type     = header_word[15:8];
      r.sequence_res   = header_word[23:16];
      r.payload_length = header_word[31:24];
      r.detail         = detail;
      r.payload_byte   = pbyte;
      r.last           = last;
      awaited_results.push_back(r);
   endfunction

   // one accepted request through the deframer copy
   function automatic void advance_deframer(input logic op, input logic [7:0] value);
      logic [15:0] rx_crc;
      int          n_pay;
      if (op == OpTick) begin
         if (parser_phase == PhHunt) return;
         if (idle_count != 16'hFFFF) idle_count++;
         if (idle_count >= cfg_timeout) begin
            queue_result(KindReport, StatusTimeout, 16'd0, 8'd0, 1'b1);
            restart_hunt();
         end
         return;
      end
      idle_count = '0;
      case (parser_phase)
         PhHunt: begin
            if (value == cfg_start_one) begin
               restart_hunt();
               parser_phase = PhStartTwo;
            end
         end
         // start two is tested before a repeated start one
         PhStartTwo: begin
            if (value == cfg_start_two) begin
               restart_hunt();
               parser_phase = PhHeader;
            end else if (value != cfg_start_one) begin
               restart_hunt();
            end
         end
         PhHeader: begin
            header_word[8*header_taken +: 8] = value;
            crc_acc = crc16_modbus_step(crc_acc, value);
            header_taken++;
            if (header_taken == 4) begin
               if (int'(header_word[31:24]) > MaxPayload) begin
                  queue_result(KindReport, StatusLength, {8'd0, header_word[31:24]},
                               8'd0, 1'b1);
                  restart_hunt();
               end else begin
                  payload_taken = 0;
                  parser_phase  = (header_word[31:24] == 8'd0) ? PhCrcLow : PhPayload;
               end
            end
         end
         PhPayload: begin
            payload_copy[payload_taken] = value;
            crc_acc = crc16_modbus_step(crc_acc, value);
            payload_taken++;
            if (payload_taken >= int'(header_word[31:24])) parser_phase = PhCrcLow;
         end
         PhCrcLow: begin
            crc_low      = value;
            parser_phase = PhCrcHigh;
         end
         default: begin
            rx_crc = {value, crc_low};
            if (rx_crc != crc_acc) begin
               queue_result(KindReport, StatusCrc, rx_crc, 8'd0, 1'b1);
            end else if (header_word[7:0] != cfg_version) begin
               queue_result(KindReport, StatusVersion, {8'd0, header_word[7:0]}, 8'd0, 1'b1);
            end else begin
               n_pay = int'(header_word[31:24]);
               queue_result(KindReport, StatusOk, rx_crc, 8'd0, n_pay == 0);
               for (int i = 0; i < n_pay; i++) begin
                  queue_result(KindPayload, StatusOk, 16'd0, payload_copy[i], i == n_pay - 1);
               end
            end
            restart_hunt();
         end
      endcase
   endfunction

   function automatic void compare_field(input string name, input logic [15:0] want,
                                         input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (awaited_results.size() == 0) begin
            $error("unexpected result: kind %0d status %0d", rsp_data.item_kind,
                   rsp_data.status);
            fail_count++;
         end else begin
            oldest_result = awaited_results.pop_front();
            compare_field("item_kind", 16'(oldest_result.item_kind),
                          16'(rsp_data.item_kind));
            compare_field("status", 16'(oldest_result.status), 16'(rsp_data.status));
            compare_field("frame_type", 16'(oldest_result.frame_type),
                          16'(rsp_data.frame_type));
            compare_field("sequence_res", 16'(oldest_result.sequence_res),
                          16'(rsp_data.sequence_res));
            compare_field("payload_length", 16'(oldest_result.payload_length),
                          16'(rsp_data.payload_length));
            compare_field("detail", oldest_result.detail, rsp_data.detail);
            compare_field("payload_byte", 16'(oldest_result.payload_byte),
                          16'(rsp_data.payload_byte));
            compare_field("last", 16'(oldest_result.last), 16'(rsp_data.last));
            if (oldest_result.item_kind == KindPayload) payload_bytes_seen++;
            else report_tally[oldest_result.status]++;
         end
      end
   end

   // one request, with a random gap ahead of it
   task automatic send_request(input logic op, input logic [7:0] value);
      while (req_gaps && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= {op, value};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      advance_deframer(op, value);
      sent_requests++;
   endtask

   task automatic send_byte(input logic [7:0] value);
      send_request(OpByte, value);
   endtask

   task automatic send_tick();
      send_request(OpTick, 8'($urandom));
   endtask

   // let every awaited result drain, then allow the block to settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_idling(input bit on);
      req_gaps   = on;
      rsp_stalls = on;
   endtask

   function automatic logic [31:0] shadow_register(input logic [1:0] idx);
      case (idx)
         RegStartOne: return {24'd0, cfg_start_one};
         RegStartTwo: return {24'd0, cfg_start_two};
         RegVersion:  return {24'd0, cfg_version};
         default:     return {16'd0, cfg_timeout};
      endcase
   endfunction

   // apb read of one register against its shadow
   task automatic check_register(input logic [1:0] idx);
      logic [31:0] got;
      logic [31:0] mask;
      mask = (idx == RegTimeout) ? 32'h0000_FFFF : 32'h0000_00FF;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= {idx, 2'b00};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      got = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      if ((got & mask) !== (shadow_register(idx) & mask)) begin
         $error("register %0d: expected 0x%0h, got 0x%0h", idx, shadow_register(idx) & mask,
                got & mask);
         fail_count++;
      end
   endtask

   // apb write, then read back
   task automatic write_register(input logic [1:0] idx, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         RegStartOne: cfg_start_one = value[7:0];
         RegStartTwo: cfg_start_two = value[7:0];
         RegVersion:  cfg_version   = value[7:0];
         default:     cfg_timeout   = value[15:0];
      endcase
      @(posedge clock);
      check_register(idx);
   endtask

   task automatic write_settings(input logic [7:0] one, input logic [7:0] two,
                                 input logic [7:0] ver, input logic [15:0] ticks);
      write_register(RegStartOne, {24'd0, one});
      write_register(RegStartTwo, {24'd0, two});
      write_register(RegVersion, {24'd0, ver});
      write_register(RegTimeout, {16'd0, ticks});
   endtask

   function automatic void fill_payload(input fill_mode_type mode);
      for (int i = 0; i < MaxPayload; i++) begin
         case (mode)
            FillOnes:      frame_payload[i] = 8'hFF;
            FillZeros:     frame_payload[i] = 8'h00;
            FillAlternate: frame_payload[i] = i[0] ? 8'hFF : 8'h00;
            default:       frame_payload[i] = 8'($urandom);
         endcase
      end
   endfunction

   // start bytes, header, payload and crc; optionally cut short or with ticks between bytes
   task automatic send_frame(input logic [7:0] ver, input logic [7:0] ftype,
                             input logic [7:0] seq, input logic [7:0] len, input bit bad_crc,
                             input int cut, input int tick_pct, input int max_ticks);
      logic [7:0]  frame_octets [$];
      logic [15:0] crc;
      int          n_send;
      frame_octets = {cfg_start_one, cfg_start_two, ver, ftype, seq, len};
      crc = CrcInit;
      for (int i = 2; i < 6; i++) crc = crc16_modbus_step(crc, frame_octets[i]);
      if (len <= MaxPayload) begin
         for (int i = 0; i < len; i++) begin
            frame_octets.push_back(frame_payload[i]);
            crc = crc16_modbus_step(crc, frame_payload[i]);
         end
         if (bad_crc) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
         frame_octets.push_back(crc[7:0]);
         frame_octets.push_back(crc[15:8]);
      end
      n_send = (cut >= 0 && cut < frame_octets.size()) ? cut : frame_octets.size();
      for (int i = 0; i < n_send; i++) begin
         if (i > 0 && $urandom_range(0, 99) < tick_pct) begin
            repeat ($urandom_range(1, max_ticks)) send_tick();
         end
         send_byte(frame_octets[i]);
      end
   endtask

   // reset values, ticks while hunting, equal zero start bytes
   task automatic test_reset_settings();
      check_register(RegStartOne);
      check_register(RegStartTwo);
      check_register(RegVersion);
      check_register(RegTimeout);
      send_tick();
      send_tick();
      fill_payload(FillRandom);
      send_frame(8'h01, 8'h00, 8'hFF, 8'd0, 1'b0, WholeFrame, 0, 1);
      wait_idle();
   endtask

   // start byte hunt: repeats, stray bytes, equal and extreme start values
   task automatic test_start_search();
      write_settings(8'hAA, 8'h55, 8'h01, 16'd50);
      fill_payload(FillRandom);
      send_byte(8'hAA);
      send_byte(8'hAA);
      send_frame(8'h01, 8'h12, 8'h34, 8'd2, 1'b0, WholeFrame, 0, 1);
      send_byte(8'hAA);
      send_byte(8'h12);
      send_byte(8'h55);
      send_frame(8'h01, 8'h56, 8'h78, 8'd1, 1'b0, WholeFrame, 0, 1);
      wait_idle();
      write_settings(8'h7E, 8'h7E, 8'h01, 16'd50);
      send_frame(8'h01, 8'h9A, 8'hBC, 8'd3, 1'b0, WholeFrame, 0, 1);
      wait_idle();
      write_settings(8'hFF, 8'h00, 8'h01, 16'd50);
      send_frame(8'h01, 8'hDE, 8'hF0, 8'd1, 1'b0, WholeFrame, 0, 1);
      wait_idle();
   endtask

   // good frames at the header and payload extremes
   task automatic test_good_frames();
      write_register(RegVersion, 32'h0000_00FF);
      fill_payload(FillOnes);
      send_frame(8'hFF, 8'hFF, 8'h00, 8'(MaxPayload), 1'b0, WholeFrame, 0, 1);
      wait_idle();
      write_register(RegVersion, 32'h0000_0000);
      fill_payload(FillZeros);
      send_frame(8'h00, 8'h00, 8'hFF, 8'd1, 1'b0, WholeFrame, 0, 1);
      fill_payload(FillAlternate);
      send_frame(8'h00, 8'h5A, 8'hA5, 8'd3, 1'b0, WholeFrame, 0, 1);
      wait_idle();
   endtask

   // each error report: length, crc, version, timeout
   task automatic test_frame_errors();
      fill_payload(FillRandom);
      send_frame(8'h00, 8'h11, 8'h22, 8'(MaxPayload + 1), 1'b0, WholeFrame, 0, 1);
      send_frame(8'h00, 8'h33, 8'h44, 8'hFF, 1'b0, WholeFrame, 0, 1);
      send_frame(8'h00, 8'h55, 8'h66, 8'd4, 1'b1, WholeFrame, 0, 1);
      send_frame(8'h01, 8'h77, 8'h88, 8'd2, 1'b0, WholeFrame, 0, 1);
      wait_idle();
      // shortest timeout: one tick drops the frame before the header is complete
      write_register(RegTimeout, 32'd1);
      send_frame(8'h00, 8'h99, 8'hAA, 8'd2, 1'b0, 3, 0, 1);
      send_tick();
      send_tick();
      wait_idle();
      // ticks below the limit, cleared by each byte
      write_register(RegTimeout, 32'd3);
      send_frame(8'h00, 8'hBB, 8'hCC, 8'd1, 1'b0, WholeFrame, 100, 2);
      send_frame(8'h00, 8'hDD, 8'hEE, 8'd5, 1'b0, 8, 0, 1);
      repeat (3) send_tick();
      wait_idle();
   endtask

   // largest timeout: idle stretches between bytes never drop the frame
   task automatic test_long_timeout();
      set_idling(1'b0);
      write_register(RegTimeout, 32'h0000_FFFF);
      fill_payload(FillRandom);
      send_frame(8'h00, 8'h0F, 8'hF0, 8'd1, 1'b0, WholeFrame, 100, 3);
      wait_idle();
      set_idling(1'b1);
   endtask

   // random settings, then mostly well-formed frames with noise and broken frames
   task automatic test_random_traffic(input int quota);
      logic [7:0]  one;
      logic [7:0]  two;
      logic [7:0]  ver;
      logic [7:0]  len;
      logic [15:0] ticks;
      int          stop_at;
      int          pick;
      case ($urandom_range(0, 3))
         0:       one = 8'h00;
         1:       one = 8'hFF;
         default: one = 8'($urandom);
      endcase
      two = ($urandom_range(0, 99) < 15) ? one : 8'($urandom);
      case ($urandom_range(0, 4))
         0:       ticks = 16'd1;
         1:       ticks = 16'hFFFF;
         2:       ticks = 16'($urandom_range(2, 6));
         default: ticks = 16'($urandom_range(7, 60));
      endcase
      write_settings(one, two, 8'($urandom), ticks);
      stop_at = sent_requests + quota;
      while (sent_requests < stop_at) begin
         pick = $urandom_range(0, 99);
         if (pick < 78) begin
            case ($urandom_range(0, 19))
               0, 1:    len = 8'(MaxPayload);
               2:       len = 8'($urandom_range(MaxPayload + 1, 255));
               3, 4, 5: len = 8'($urandom_range(7, MaxPayload - 1));
               default: len = 8'($urandom_range(0, 6));
            endcase
            ver = ($urandom_range(0, 99) < 88) ? cfg_version : 8'($urandom);
            fill_payload(FillRandom);
            send_frame(ver, 8'($urandom), 8'($urandom), len, $urandom_range(0, 99) < 8,
                       ($urandom_range(0, 99) < 8) ? $urandom_range(1, 8) : WholeFrame,
                       10, 2);
         end else if (pick < 90) begin
            // noise: stray bytes and ticks
            repeat ($urandom_range(1, 4)) begin
               if ($urandom_range(0, 1)) send_tick();
               else send_byte(($urandom_range(0, 99) < 30) ? cfg_start_one : 8'($urandom));
            end
         end else begin
            // frame abandoned after its start bytes
            send_byte(cfg_start_one);
            send_byte(cfg_start_two);
            repeat ((cfg_timeout <= 20) ? cfg_timeout : 3) send_tick();
         end
      end
      wait_idle();
   endtask

   initial begin
      set_idling(1'b1);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      restart_hunt();

      test_reset_settings();
      test_start_search();
      test_good_frames();
      test_frame_errors();
      test_long_timeout();
      test_random_traffic(3);
      test_random_traffic(3);
      // stretch with no idling on either side
      set_idling(1'b0);
      test_random_traffic(15);
      set_idling(1'b1);

      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (2 * MaxPayload + 16) @(posedge clock);

      $display("tb: %0d requests sent, %0d results checked, %0d of them payload bytes",
               sent_requests, results_seen, payload_bytes_seen);
      $display("tb: reports ok %0d, crc %0d, length %0d, version %0d, timeout %0d",
               report_tally[StatusOk], report_tally[StatusCrc], report_tally[StatusLength],
               report_tally[StatusVersion], report_tally[StatusTimeout]);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
